// File: hdl/vdof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdof_pkg
// Shared constants of the voxel dedup obstacle filter.
// ----------------------------------------------------------------------------
package vdof_pkg;

	localparam int COORD_W = 24;
	localparam int CELL_W  = 21;
	localparam int KEY_W   = 3 * CELL_W;
	localparam int KEY_SHIFT_Y = CELL_W;
	localparam int KEY_SHIFT_X = 2 * CELL_W;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INNER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOXEL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP    = 3'd5;

endpackage

// File: hdl/vdof_floor_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdof_floor_div
// Restoring bit-serial floor division of a signed 24-bit value by an unsigned
// 16-bit divisor, one quotient bit per cycle; result masked to the cell width.
// ----------------------------------------------------------------------------
module vdof_floor_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [vdof_pkg::COORD_W-1:0] dividend,
	input  logic [15:0]                         divisor,
	output logic                                busy,
	output logic                                done,
	output logic [vdof_pkg::CELL_W-1:0]         quot
);

	localparam int W = vdof_pkg::COORD_W;

	logic [W-1:0]      quo_q;
	logic [16:0]       rem_q;
	logic [4:0]        cnt_q;
	logic              neg_q;
	logic [15:0]       dvs_q;
	logic              busy_q;
	logic              done_q;
	logic [16:0]       trial;
	logic [17:0]       shifted;
	logic [W-1:0]      mag;
	logic [W-1:0]      qfin;

	assign mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = 17'(shifted - {2'b00, dvs_q});

	// magnitude quotient, then floor correction for a negative value with remainder
	always_comb begin
		qfin = quo_q;
		if (neg_q) begin
			qfin = ~quo_q + W'(1);
			if (rem_q != '0) qfin = qfin - W'(1);
		end
	end

	assign quot = qfin[vdof_pkg::CELL_W-1:0];
	assign busy = busy_q;
	assign done = done_q;

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[W-1];
			dvs_q <= (divisor == '0) ? 16'd1 : divisor;
		end else if (busy_q) begin
			if (shifted >= {2'b00, dvs_q}) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[16:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

// File: hdl/voxel_dedup_obstacle_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_dedup_obstacle_filter_core
// Point gate, voxel key builder and per-cloud key dedup store.
// ----------------------------------------------------------------------------
// One point at a time. A point that is not finite, or arrives at a full
// cloud, is rejected at the first squaring step; one outside the range or
// height band is rejected after the squaring. A point inside the bands is
// squared through one shared 25x25 multiplier, goes through three bit-serial
// floor divisions through one shared divider, then is compared with each
// stored key of the current cloud in turn (the key store has one read port).
// The result waits in an output register; the next point is taken once it
// is delivered.
module voxel_dedup_obstacle_filter_core #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vdof_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vdof_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [vdof_pkg::COORD_W-1:0] pos_x_mm,
	input  logic signed [vdof_pkg::COORD_W-1:0] pos_y_mm,
	input  logic signed [vdof_pkg::COORD_W-1:0] pos_z_mm,
	input  logic                                is_finite,
	input  logic                                cloud_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                accepted,
	output logic signed [vdof_pkg::COORD_W-1:0] out_x_mm,
	output logic signed [vdof_pkg::COORD_W-1:0] out_y_mm,
	output logic signed [vdof_pkg::COORD_W-1:0] out_z_mm,
	output logic [10:0]                         accepted_count,
	output logic                                cap_reached
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = AW + 1;
	localparam int W  = vdof_pkg::COORD_W;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SQ    = 10'b0000000010,
		ST_GATE  = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_DWAIT = 10'b0000010000,
		ST_SRCH  = 10'b0000100000,
		ST_SCMP  = 10'b0001000000,
		ST_WRITE = 10'b0010000000,
		ST_OUT   = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] inner_q, outer_q, voxel_q;
	logic signed [15:0] minz_q, maxz_q;
	logic [10:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= 16'd0;
			outer_q <= 16'd5000;
			minz_q  <= -16'sd500;
			maxz_q  <= 16'sd2000;
			voxel_q <= 16'd50;
			cap_q   <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				vdof_pkg::REG_INNER: inner_q <= cfg_data;
				vdof_pkg::REG_OUTER: outer_q <= cfg_data;
				vdof_pkg::REG_MIN_Z: minz_q  <= cfg_data;
				vdof_pkg::REG_MAX_Z: maxz_q  <= cfg_data;
				vdof_pkg::REG_VOXEL: voxel_q <= cfg_data;
				vdof_pkg::REG_CAP:   cap_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// effective cap, clamped to 1..MAX_POINTS
	logic [CW:0] cap_eff;
	always_comb begin
		if (cap_q == '0) cap_eff = (CW+1)'(1);
		else if (32'(cap_q) > 32'(MAX_POINTS))
			cap_eff = (CW+1)'(MAX_POINTS);
		else cap_eff = (CW+1)'(cap_q);
	end

	// point registers
	logic signed [W-1:0] x_q, y_q, z_q;
	logic fin_q;
	logic [CW-1:0] count_q;
	logic full_q;
	logic acc_q;
	logic [1:0] step_q;
	logic [1:0] axis_q;
	logic [49:0] r2_q;
	logic [33:0] in2_q, out2_q;
	logic [vdof_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0] idx_q;
	logic found_q;
	logic [vdof_pkg::KEY_W-1:0] rd_key_q;
	logic out_valid_q;

	// shared multiplier, squared operand picked by step
	logic [W:0] mul_a;
	logic [49:0] mul_p;
	always_comb begin
		case (step_q)
			2'd0: mul_a = x_q[W-1] ? -((W+1)'(x_q)) : (W+1)'(x_q);
			2'd1: mul_a = y_q[W-1] ? -((W+1)'(y_q)) : (W+1)'(y_q);
			2'd2: mul_a = (W+1)'(inner_q);
			default: mul_a = (W+1)'(outer_q);
		endcase
	end
	assign mul_p = 50'(mul_a * mul_a);

	// divider
	logic div_start, div_busy, div_done;
	logic signed [W-1:0] div_in;
	logic [vdof_pkg::CELL_W-1:0] div_quot;
	assign div_in = (axis_q == 2'd0) ? x_q : (axis_q == 2'd1) ? y_q : z_q;
	assign div_start = (state_q == ST_DIV);

	vdof_floor_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.divisor(voxel_q), .busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// key store
	logic [vdof_pkg::KEY_W-1:0] keys_mem [MAX_POINTS];
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) keys_mem[count_q[AW-1:0]] <= key_q;
		rd_key_q <= keys_mem[idx_q[AW-1:0]];
	end

	logic gate_ok;
	assign gate_ok = (r2_q >= 50'(in2_q)) && (r2_q <= 50'(out2_q))
		&& (z_q >= W'(minz_q)) && (z_q <= W'(maxz_q));

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
			step_q      <= '0;
			axis_q      <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			fin_q       <= 1'b0;
			r2_q        <= '0;
			in2_q       <= '0;
			out2_q      <= '0;
			key_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q <= pos_x_mm; y_q <= pos_y_mm; z_q <= pos_z_mm;
						fin_q <= is_finite;
						acc_q <= 1'b0;
						step_q <= '0;
						if (cloud_start) begin
							count_q <= '0;
							full_q  <= 1'b0;
						end
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					// full check happens on the first squaring step
					if (step_q == 2'd0 && ((CW+1)'(count_q) >= cap_eff)) full_q <= 1'b1;
					if (step_q == 2'd0 && (((CW+1)'(count_q) >= cap_eff) || full_q || !fin_q))
						state_q <= ST_OUT;
					else begin
						case (step_q)
							2'd0: r2_q <= mul_p;
							2'd1: r2_q <= r2_q + mul_p;
							2'd2: in2_q <= mul_p[33:0];
							default: out2_q <= mul_p[33:0];
						endcase
						step_q <= step_q + 2'd1;
						if (step_q == 2'd3) state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					axis_q  <= '0;
					state_q <= gate_ok ? ST_DIV : ST_OUT;
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						key_q <= {key_q[vdof_pkg::KEY_W-vdof_pkg::CELL_W-1:0], div_quot};
						if (axis_q == 2'd2) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SRCH;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_SRCH: begin
					// issue read of entry idx_q, or finish scan
					if (idx_q >= count_q) state_q <= ST_WRITE;
					else state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (rd_key_q == key_q) state_q <= ST_OUT;
					else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_SRCH;
					end
				end
				ST_WRITE: begin
					acc_q   <= 1'b1;
					count_q <= count_q + CW'(1);
					if ((CW+1)'(count_q) + (CW+1)'(1) >= cap_eff) full_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign accepted       = acc_q;
	assign out_x_mm       = x_q;
	assign out_y_mm       = y_q;
	assign out_z_mm       = z_q;
	assign accepted_count = 11'(count_q);
	assign cap_reached    = full_q;

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(count_q) <= (CW+1)'(MAX_POINTS))
		else $error("key count above store depth");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_acc_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (accepted_count != '0))
		else $error("accepted point with zero count");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy || div_done) |-> (state_q == ST_DWAIT))
		else $error("divider running outside wait");

endmodule

// File: tb/voxel_dedup_obstacle_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_dedup_obstacle_filter_core_tb
// Self-checking bench for the voxel dedup obstacle filter core.
// ----------------------------------------------------------------------------
// A directed table of points runs first, with hand-written results where they
// are obvious; then random clouds over several register settings, under
// changing sender gaps and receiver stalls. Every result beat is checked field
// by field against its hand-written result, else the in-bench filter model.
// ----------------------------------------------------------------------------
module voxel_dedup_obstacle_filter_core_tb;

	localparam int MAXP  = 1024;
	localparam int CRD_W = vdof_pkg::COORD_W;
	localparam int CEL_W = vdof_pkg::CELL_W;
	localparam int KY_W  = vdof_pkg::KEY_W;
	localparam int IDX_W = vdof_pkg::CFG_IDX_W;
	localparam int DAT_W = vdof_pkg::CFG_DATA_W;

	typedef struct {
		logic signed [CRD_W-1:0] x, y, z;
		logic                    fin, start;
	} point_t;

	typedef struct {
		logic                    acc;
		logic signed [CRD_W-1:0] x, y, z;
		logic [10:0]             cnt;
		logic                    full;
	} verdict_t;

	typedef struct {
		point_t   p;
		logic     known;
		verdict_t v;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DAT_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall;
	logic signed [CRD_W-1:0] pos_x_mm = '0, pos_y_mm = '0, pos_z_mm = '0;
	logic is_finite = 0, cloud_start = 0;
	logic out_valid, out_stall = 0, accepted, cap_reached;
	logic signed [CRD_W-1:0] out_x_mm, out_y_mm, out_z_mm;
	logic [10:0] accepted_count;

	voxel_dedup_obstacle_filter_core #(.MAX_POINTS(MAXP)) DUT (.*);

	initial forever #2 clk = ~clk;

	// filter model state
	logic [15:0] m_inner, m_outer, m_voxel;
	logic signed [15:0] m_zlo, m_zhi;
	logic [10:0] m_cap;
	logic [KY_W-1:0] m_keys[MAXP];
	int m_count;
	logic m_full;

	verdict_t pending_q[$];
	int  errors = 0;
	int  send_idle = 0, recv_stall = 0;

	function automatic logic [CEL_W-1:0] floor_cell(longint v, longint sz);
		longint q;
		q = v / sz;
		if ((v % sz) != 0 && v < 0) q -= 1;
		return q[CEL_W-1:0];
	endfunction

	function automatic verdict_t filter_point(point_t p);
		verdict_t r;
		longint x, y, z, r2, sz;
		int cap;
		logic [KY_W-1:0] key;
		logic hit;
		x = p.x; y = p.y; z = p.z;
		r.acc = 0;
		if (p.start) begin
			m_count = 0;
			m_full = 0;
		end
		cap = (m_cap == 0) ? 1 : (m_cap > MAXP ? MAXP : m_cap);
		if (m_count >= cap) m_full = 1;
		r2 = x * x + y * y;
		if (!m_full && p.fin && r2 >= longint'(m_inner) * m_inner
				&& r2 <= longint'(m_outer) * m_outer && z >= m_zlo && z <= m_zhi) begin
			sz = (m_voxel == 0) ? 1 : m_voxel;
			key = {floor_cell(x, sz), floor_cell(y, sz), floor_cell(z, sz)};
			hit = 0;
			for (int i = 0; i < m_count; i++)
				if (m_keys[i] == key) hit = 1;
			if (!hit && m_count < MAXP) begin
				m_keys[m_count] = key;
				m_count++;
				r.acc = 1;
				if (m_count >= cap) m_full = 1;
			end
		end
		r.x = p.x; r.y = p.y; r.z = p.z;
		r.cnt = m_count[10:0];
		r.full = m_full;
		return r;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			vdof_pkg::REG_INNER: m_inner = val;
			vdof_pkg::REG_OUTER: m_outer = val;
			vdof_pkg::REG_MIN_Z: m_zlo = val;
			vdof_pkg::REG_MAX_Z: m_zhi = val;
			vdof_pkg::REG_VOXEL: m_voxel = val;
			vdof_pkg::REG_CAP:   m_cap = val[10:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait for all results, then settle before touching registers
	task automatic drain();
		in_valid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// one beat, with optional known result checked against the model too
	task automatic send_point(point_t p, logic known, verdict_t v);
		verdict_t pred;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pos_x_mm <= p.x; pos_y_mm <= p.y; pos_z_mm <= p.z;
		is_finite <= p.fin; cloud_start <= p.start;
		// stall is settled by the falling edge; the next rising edge takes the beat
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		pred = filter_point(p);
		if (known && (pred.acc != v.acc || pred.cnt != v.cnt || pred.full != v.full)) begin
			$error("directed row disagrees with model: acc %0d cnt %0d full %0d",
				v.acc, v.cnt, v.full);
			errors++;
		end
		if (!known) v = pred;
		pending_q = {pending_q, v};
	endtask

	// result checking
	always @(posedge clk) begin
		verdict_t e;
		if (out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (accepted !== e.acc) begin
					$error("accepted exp %0d got %0d", e.acc, accepted); errors++;
				end
				if (out_x_mm !== e.x) begin
					$error("out_x_mm exp %0d got %0d", e.x, out_x_mm); errors++;
				end
				if (out_y_mm !== e.y) begin
					$error("out_y_mm exp %0d got %0d", e.y, out_y_mm); errors++;
				end
				if (out_z_mm !== e.z) begin
					$error("out_z_mm exp %0d got %0d", e.z, out_z_mm); errors++;
				end
				if (accepted_count !== e.cnt) begin
					$error("accepted_count exp %0d got %0d", e.cnt, accepted_count); errors++;
				end
				if (cap_reached !== e.full) begin
					$error("cap_reached exp %0d got %0d", e.full, cap_reached); errors++;
				end
			end
		end
		out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
	end

	function automatic point_t mk(int x, int y, int z, bit f, bit s);
		point_t p;
		p.x = CRD_W'(x); p.y = CRD_W'(y); p.z = CRD_W'(z); p.fin = f; p.start = s;
		return p;
	endfunction

	function automatic verdict_t vk(point_t p, bit a, int c, bit f);
		verdict_t v;
		v.acc = a; v.x = p.x; v.y = p.y; v.z = p.z; v.cnt = 11'(c); v.full = f;
		return v;
	endfunction

	// random point near the bands, sometimes anywhere
	function automatic point_t rand_point(int span, bit s);
		point_t p;
		if ($urandom_range(9) == 0) begin
			p.x = CRD_W'($urandom); p.y = CRD_W'($urandom); p.z = CRD_W'($urandom);
		end else begin
			p.x = CRD_W'($signed($urandom_range(2 * span)) - span);
			p.y = CRD_W'($signed($urandom_range(2 * span)) - span);
			p.z = CRD_W'($signed($urandom_range(2 * span)) - span);
		end
		p.fin = ($urandom_range(19) != 0);
		p.start = s;
		return p;
	endfunction

	task automatic set_phase(int k);
		case (k % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 69; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 69; end
			default: begin send_idle = 16; recv_stall = 16; end
		endcase
	endtask

	initial begin
		row_t rows[$];
		point_t p;
		int sent, span, clouds;
		m_inner = 0; m_outer = 5000; m_zlo = -500; m_zhi = 2000; m_voxel = 50;
		m_cap = 1024; m_count = 0; m_full = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table at reset settings
		p = mk(0, 0, 0, 1, 1);        rows = {rows, row_t'{p, 1'b1, vk(p, 1, 1, 0)}};
		p = mk(10, 10, 10, 1, 0);     rows = {rows, row_t'{p, 1'b1, vk(p, 0, 1, 0)}};
		p = mk(100, 0, 0, 0, 0);      rows = {rows, row_t'{p, 1'b1, vk(p, 0, 1, 0)}};
		p = mk(5000, 0, 0, 1, 0);     rows = {rows, row_t'{p, 1'b1, vk(p, 1, 2, 0)}};
		p = mk(5001, 0, 0, 1, 0);     rows = {rows, row_t'{p, 1'b1, vk(p, 0, 2, 0)}};
		p = mk(0, -5000, -500, 1, 0); rows = {rows, row_t'{p, 1'b1, vk(p, 1, 3, 0)}};
		p = mk(0, 0, -501, 1, 0);     rows = {rows, row_t'{p, 1'b1, vk(p, 0, 3, 0)}};
		p = mk(0, 0, 2001, 1, 0);     rows = {rows, row_t'{p, 1'b1, vk(p, 0, 3, 0)}};
		p = mk(-1, -1, 2000, 1, 0);   rows = {rows, row_t'{p, 1'b0, vk(p, 0, 0, 0)}};
		p = mk(-8388608, -8388608, -8388608, 1, 0);
		rows = {rows, row_t'{p, 1'b1, vk(p, 0, 4, 0)}};
		p = mk(8388607, 8388607, 8388607, 1, 0);
		rows = {rows, row_t'{p, 1'b1, vk(p, 0, 4, 0)}};
		p = mk(-49, 49, -50, 1, 0);   rows = {rows, row_t'{p, 1'b0, vk(p, 0, 0, 0)}};
		p = mk(-50, 0, 0, 1, 1);      rows = {rows, row_t'{p, 1'b1, vk(p, 1, 1, 0)}};
		foreach (rows[i]) send_point(rows[i].p, rows[i].known, rows[i].v);
		drain();

		// degenerate settings: zero voxel, zero cap, empty bands
		write_reg(vdof_pkg::REG_VOXEL, 16'd0);
		write_reg(vdof_pkg::REG_CAP, 16'd0);
		p = mk(3, 4, 5, 1, 1);   send_point(p, 1, vk(p, 1, 1, 1));
		p = mk(7, 4, 5, 1, 0);   send_point(p, 1, vk(p, 0, 1, 1));
		drain();
		write_reg(vdof_pkg::REG_CAP, 16'h07ff);
		write_reg(vdof_pkg::REG_INNER, 16'd100);
		write_reg(vdof_pkg::REG_OUTER, 16'd50);
		p = mk(70, 0, 0, 1, 1);  send_point(p, 1, vk(p, 0, 0, 0));
		drain();
		write_reg(vdof_pkg::REG_INNER, 16'd0);
		write_reg(vdof_pkg::REG_OUTER, 16'd65535);
		write_reg(vdof_pkg::REG_MIN_Z, 16'sd10);
		write_reg(vdof_pkg::REG_MAX_Z, -16'sd10);
		p = mk(1, 1, 0, 1, 0);   send_point(p, 1, vk(p, 0, 0, 0));
		drain();
		write_reg(vdof_pkg::REG_MIN_Z, 16'h8000);
		write_reg(vdof_pkg::REG_MAX_Z, 16'h7fff);
		write_reg(vdof_pkg::REG_INNER, 16'd65535);
		p = mk(65535, 0, -32768, 1, 0); send_point(p, 1, vk(p, 1, 1, 0));
		p = mk(0, 65535, 32767, 1, 0);  send_point(p, 1, vk(p, 1, 2, 0));
		drain();

		// random clouds over a spread of settings
		sent = 0; clouds = 0;
		while (sent < 2000) begin
			set_phase(clouds);
			write_reg(vdof_pkg::REG_INNER,
				16'($urandom_range(3) == 0 ? 0 : $urandom_range(300)));
			write_reg(vdof_pkg::REG_OUTER,
				16'($urandom_range(4) == 0 ? 65535 : $urandom_range(200, 3000)));
			write_reg(vdof_pkg::REG_MIN_Z,
				16'($urandom_range(4) == 0 ? 32'h8000 : -$urandom_range(2000)));
			write_reg(vdof_pkg::REG_MAX_Z,
				16'($urandom_range(4) == 0 ? 32'h7fff : $urandom_range(2000)));
			write_reg(vdof_pkg::REG_VOXEL, 16'($urandom_range(5) == 0 ? $urandom_range(65535)
				: $urandom_range(20, 400)));
			write_reg(vdof_pkg::REG_CAP,
				16'($urandom_range(7) == 0 ? 32'h7ff : $urandom_range(1, 60)));
			span = $urandom_range(500, 3000);
			for (int i = 0; i < 60; i++) begin
				p = rand_point(span, (i == 0) || ($urandom_range(49) == 0));
				send_point(p, 0, vk(p, 0, 0, 0));
				sent++;
				// set a small cap mid-cloud now and then
				if (i == 30 && $urandom_range(3) == 0) begin
					drain();
					write_reg(vdof_pkg::REG_CAP, 16'($urandom_range(1, 8)));
				end
			end
			drain();
			clouds++;
		end

		set_phase(0);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
